// ===== src/dcep_pkg.sv =====
// ---------------------------------------------------------------------------
// dcep_pkg
// Shared types and constants for the two-channel event-scheduled PWM.
// ---------------------------------------------------------------------------
package dcep_pkg;

  // Command codes, shared by the input port decode and the internal queue
  typedef enum logic [1:0] {
    CMD_EXPIRY = 2'd0,
    CMD_MOTOR  = 2'd1,
    CMD_TONE   = 2'd2,
    CMD_VOLUME = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam logic CFG_MOTOR_PERIOD  = 1'b0;
  localparam logic CFG_BUZZER_PERIOD = 1'b1;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned SPEED_W = 14;
  localparam int unsigned VOL_W   = 8;

  localparam logic [TICK_W-1:0] MOTOR_PERIOD_RST  = 16'd400;
  localparam logic [TICK_W-1:0] BUZZER_PERIOD_RST = 16'd1000;
  localparam logic [TICK_W-1:0] MIN_PERIOD        = 16'd2;
  localparam logic [6:0]        VOLUME_RST        = 7'd10;
  localparam logic [6:0]        VOLUME_MAX        = 7'd100;
  localparam logic [5:0]        VOLUME_CAP        = 6'd50;
  localparam logic [SPEED_W-1:0] SPEED_FULL       = 14'd10000;

  // floor(x/10000) for x < 2^30 as (x * MOTOR_RECIP) >> MOTOR_SHIFT
  localparam int unsigned        MOTOR_PROD_W = 30;
  localparam int unsigned        MOTOR_SHIFT  = 44;
  localparam logic [30:0]        MOTOR_RECIP  = 31'd1759218605;
  // floor(x/100) for x < 2^22 as (x * BUZZER_RECIP) >> BUZZER_SHIFT
  localparam int unsigned        BUZZER_PROD_W = 22;
  localparam int unsigned        BUZZER_SHIFT  = 29;
  localparam logic [22:0]        BUZZER_RECIP  = 23'd5368710;

  localparam int unsigned TIMER_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Classified command handed from the front end to the sequencer
  typedef struct packed {
    cmd_e              op;
    logic              on;
    logic [TICK_W-1:0] high;
    logic [TICK_W-1:0] low;
  } back_cmd_t;

endpackage

// ===== src/dcep_front.sv =====
// ---------------------------------------------------------------------------
// dcep_front
// Accepts commands, computes high/low times for the duty or volume and
// pushes a classified command into the queue.
// ---------------------------------------------------------------------------
module dcep_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [dcep_pkg::TICK_W-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [dcep_pkg::SPEED_W-1:0]        speed_hundredths_i,
  input  logic                                buzzer_on_i,
  input  logic [dcep_pkg::VOL_W-1:0]          volume_percent_i,
  output logic                                push_o,
  output dcep_pkg::back_cmd_t                 push_data_o,
  input  logic                                full_i
);

  localparam int unsigned TW = dcep_pkg::TICK_W;

  logic [TW-1:0] mper_q, bper_q;
  logic [6:0]    vol_q;

  logic [TW-1:0] mp, bp;
  logic [5:0]    vin50, vst50, volsel;
  logic          accept, adv;

  // stage 0: products
  logic                              s0_v_q;
  dcep_pkg::cmd_e                    s0_cmd_q;
  logic [dcep_pkg::SPEED_W-1:0]      s0_speed_q;
  logic                              s0_bon_q;
  logic [dcep_pkg::MOTOR_PROD_W-1:0] s0_mprod_q;
  logic [dcep_pkg::BUZZER_PROD_W-1:0] s0_bprod_q;
  logic [TW-1:0]                     s0_mp_q, s0_bp_q;

  // stage 1: quotients
  logic                              s1_v_q;
  dcep_pkg::cmd_e                    s1_cmd_q;
  logic                              s1_zero_q, s1_full_q, s1_bon_q;
  logic [TW-1:0]                     s1_mq_q, s1_bq_q, s1_mp_q, s1_bp_q;

  logic [60:0] mrecip_prod;
  logic [44:0] brecip_prod;
  logic [TW-1:0] mhigh, bhigh;

  function automatic logic [TW-1:0] clamp_high(input logic [TW-1:0] high,
                                               input logic [TW-1:0] period);
    logic [TW-1:0] h;
    h = (high == '0) ? TW'(1) : high;
    if (h >= period) h = period - TW'(1);
    return h;
  endfunction

  assign mp = (mper_q < dcep_pkg::MIN_PERIOD) ? dcep_pkg::MIN_PERIOD : mper_q;
  assign bp = (bper_q < dcep_pkg::MIN_PERIOD) ? dcep_pkg::MIN_PERIOD : bper_q;

  assign vin50 = (volume_percent_i > dcep_pkg::VOL_W'(dcep_pkg::VOLUME_CAP))
                 ? dcep_pkg::VOLUME_CAP : volume_percent_i[5:0];
  assign vst50 = (vol_q > 7'(dcep_pkg::VOLUME_CAP)) ? dcep_pkg::VOLUME_CAP : vol_q[5:0];
  assign volsel = (dcep_pkg::cmd_e'(command_i) == dcep_pkg::CMD_VOLUME) ? vin50 : vst50;

  // pipeline moves unless stage 1 holds a command the queue cannot take
  assign adv        = !(s1_v_q && full_i);
  assign in_stall_o = s0_v_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = s1_v_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mper_q <= dcep_pkg::MOTOR_PERIOD_RST;
      bper_q <= dcep_pkg::BUZZER_PERIOD_RST;
      vol_q  <= dcep_pkg::VOLUME_RST;
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dcep_pkg::CFG_MOTOR_PERIOD:  mper_q <= cfg_data_i;
          dcep_pkg::CFG_BUZZER_PERIOD: bper_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && dcep_pkg::cmd_e'(command_i) == dcep_pkg::CMD_VOLUME) begin
        vol_q <= (volume_percent_i > 8'(dcep_pkg::VOLUME_MAX)) ? dcep_pkg::VOLUME_MAX
                                                               : volume_percent_i[6:0];
      end
      if (accept) begin
        s0_v_q <= 1'b1;
      end else if (adv) begin
        s0_v_q <= 1'b0;
      end
      if (adv) begin
        s1_v_q <= s0_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_cmd_q   <= dcep_pkg::cmd_e'(command_i);
      s0_speed_q <= speed_hundredths_i;
      s0_bon_q   <= buzzer_on_i;
      s0_mprod_q <= dcep_pkg::MOTOR_PROD_W'(mp) * dcep_pkg::MOTOR_PROD_W'(speed_hundredths_i);
      s0_bprod_q <= dcep_pkg::BUZZER_PROD_W'(bp) * dcep_pkg::BUZZER_PROD_W'(volsel);
      s0_mp_q    <= mp;
      s0_bp_q    <= bp;
    end
    if (adv && s0_v_q) begin
      s1_cmd_q  <= s0_cmd_q;
      s1_zero_q <= (s0_speed_q == '0);
      s1_full_q <= (s0_speed_q >= dcep_pkg::SPEED_FULL);
      s1_bon_q  <= s0_bon_q;
      s1_mq_q   <= mrecip_prod[dcep_pkg::MOTOR_SHIFT +: TW];
      s1_bq_q   <= brecip_prod[dcep_pkg::BUZZER_SHIFT +: TW];
      s1_mp_q   <= s0_mp_q;
      s1_bp_q   <= s0_bp_q;
    end
  end

  // constant division by reciprocal multiply
  assign mrecip_prod = 61'(s0_mprod_q) * 61'(dcep_pkg::MOTOR_RECIP);
  assign brecip_prod = 45'(s0_bprod_q) * 45'(dcep_pkg::BUZZER_RECIP);

  assign mhigh = clamp_high(s1_mq_q, s1_mp_q);
  assign bhigh = clamp_high(s1_bq_q, s1_bp_q);

  always_comb begin
    push_data_o.op   = s1_cmd_q;
    push_data_o.on   = 1'b0;
    push_data_o.high = '0;
    push_data_o.low  = '0;
    case (s1_cmd_q)
      dcep_pkg::CMD_MOTOR: begin
        if (s1_zero_q) begin
          push_data_o.low = TW'(1);
        end else if (s1_full_q) begin
          push_data_o.on   = 1'b1;
          push_data_o.high = TW'(1);
        end else begin
          push_data_o.on   = 1'b1;
          push_data_o.high = mhigh;
          push_data_o.low  = s1_mp_q - mhigh;
        end
      end
      dcep_pkg::CMD_TONE: begin
        if (s1_bon_q) begin
          push_data_o.on   = 1'b1;
          push_data_o.high = bhigh;
          push_data_o.low  = s1_bp_q - bhigh;
        end else begin
          push_data_o.low = TW'(1);
        end
      end
      dcep_pkg::CMD_VOLUME: begin
        push_data_o.on   = 1'b1;
        push_data_o.high = bhigh;
        push_data_o.low  = s1_bp_q - bhigh;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/dcep_queue.sv =====
// ---------------------------------------------------------------------------
// dcep_queue
// Small FIFO of classified commands between front end and sequencer.
// ---------------------------------------------------------------------------
module dcep_queue #(
  parameter int unsigned Depth = dcep_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dcep_pkg::back_cmd_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output dcep_pkg::back_cmd_t pop_data_o,
  output logic                empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dcep_pkg::back_cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // front end must respect the full flag, sequencer the empty flag
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");

endmodule

// ===== src/dcep_back.sv =====
// ---------------------------------------------------------------------------
// dcep_back
// Sequencer: unless the output stalls, applies one queued command per cycle
// to the channel state, reschedules the shared timer, registers the result.
// ---------------------------------------------------------------------------
module dcep_back #(
  parameter int unsigned TimerBits = dcep_pkg::TIMER_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dcep_pkg::back_cmd_t          cmd_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         motor_level_o,
  output logic                         buzzer_level_o,
  output logic                         timer_running_o,
  output logic [dcep_pkg::TICK_W-1:0]  tick_delta_o,
  output logic [dcep_pkg::TICK_W-1:0]  timer_reload_o
);

  localparam int unsigned TW = dcep_pkg::TICK_W;
  localparam logic [32:0] Full = 33'(1) << TimerBits;
  localparam logic [32:0] DMax = Full - 33'(1);

  typedef struct packed {
    logic          act;
    logic          pin;
    logic [TW-1:0] left;
  } chan_t;

  chan_t         m_q, m_d, b_q, b_d;
  logic [TW-1:0] m_high_q, m_high_d, m_low_q, m_low_d;
  logic [TW-1:0] b_high_q, b_high_d, b_low_q, b_low_d;
  logic [TW-1:0] delta_q, delta_d;
  logic          armed_q, armed_d;
  logic          resched;
  logic          out_v_q;
  logic [32:0]   dcl, rel;

  function automatic chan_t chan_en(input logic on, input logic [TW-1:0] high,
                                    input logic [TW-1:0] low);
    chan_t c;
    if (!on || high == '0) begin
      c = '{act: 1'b0, pin: 1'b0, left: TW'(1)};
    end else if (low == '0) begin
      c = '{act: 1'b0, pin: 1'b1, left: TW'(1)};
    end else begin
      c = '{act: 1'b1, pin: 1'b1, left: high};
    end
    return c;
  endfunction

  function automatic chan_t chan_adv(input chan_t c, input logic [TW-1:0] high,
                                     input logic [TW-1:0] low,
                                     input logic [TW-1:0] delta);
    chan_t r;
    r = c;
    if (c.act) begin
      r.left = (c.left > delta) ? c.left - delta : '0;
      if (r.left == '0) begin
        r.pin  = !c.pin;
        r.left = r.pin ? high : low;
      end
    end
    return r;
  endfunction

  assign pop_o = !empty_i && (!out_v_q || !out_stall_i);

  always_comb begin
    m_d      = m_q;
    b_d      = b_q;
    m_high_d = m_high_q;
    m_low_d  = m_low_q;
    b_high_d = b_high_q;
    b_low_d  = b_low_q;
    resched  = 1'b1;
    case (cmd_i.op)
      dcep_pkg::CMD_EXPIRY: begin
        m_d = chan_adv(m_q, m_high_q, m_low_q, delta_q);
        b_d = chan_adv(b_q, b_high_q, b_low_q, delta_q);
      end
      dcep_pkg::CMD_MOTOR: begin
        m_high_d = cmd_i.high;
        m_low_d  = cmd_i.low;
        m_d      = chan_en(cmd_i.on, cmd_i.high, cmd_i.low);
      end
      dcep_pkg::CMD_TONE: begin
        b_high_d = cmd_i.high;
        b_low_d  = cmd_i.low;
        b_d      = chan_en(cmd_i.on, cmd_i.high, cmd_i.low);
      end
      dcep_pkg::CMD_VOLUME: begin
        // new volume only re-arms a running tone
        if (b_q.act) begin
          b_high_d = cmd_i.high;
          b_low_d  = cmd_i.low;
          b_d      = chan_en(1'b1, cmd_i.high, cmd_i.low);
        end else begin
          resched = 1'b0;
        end
      end
      default: ;
    endcase

    delta_d = delta_q;
    armed_d = armed_q;
    if (resched) begin
      armed_d = m_d.act || b_d.act;
      if (m_d.act && b_d.act) begin
        delta_d = (m_d.left < b_d.left) ? m_d.left : b_d.left;
      end else if (m_d.act) begin
        delta_d = m_d.left;
      end else if (b_d.act) begin
        delta_d = b_d.left;
      end else begin
        delta_d = TW'(1);
      end
    end
  end

  // reload = 2^TimerBits - delta, delta clamped to 1..2^TimerBits-1
  always_comb begin
    dcl = 33'(delta_d);
    if (dcl == '0) dcl = 33'(1);
    if (dcl > DMax) dcl = DMax;
    rel = Full - dcl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q      <= '0;
      b_q      <= '0;
      m_high_q <= '0;
      m_low_q  <= '0;
      b_high_q <= '0;
      b_low_q  <= '0;
      delta_q  <= TW'(1);
      armed_q  <= 1'b1;
      out_v_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        m_q      <= m_d;
        b_q      <= b_d;
        m_high_q <= m_high_d;
        m_low_q  <= m_low_d;
        b_high_q <= b_high_d;
        b_low_q  <= b_low_d;
        delta_q  <= delta_d;
        armed_q  <= armed_d;
        out_v_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      motor_level_o   <= m_d.pin;
      buzzer_level_o  <= b_d.pin;
      timer_running_o <= armed_d;
      tick_delta_o    <= delta_d;
      timer_reload_o  <= rel[TW-1:0];
    end
  end

  assign out_valid_o = out_v_q;

  a_act_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_q.act || b_q.act) |-> armed_q) else $error("channel running, timer stopped");
  a_stop_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q |-> (delta_q == TW'(1))) else $error("stopped timer with delta != 1");
  a_m_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_q.act |-> (m_q.left != '0 && m_high_q != '0 && m_low_q != '0))
    else $error("running motor channel with zero count");
  a_b_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_q.act |-> (b_q.left != '0 && b_high_q != '0 && b_low_q != '0))
    else $error("running buzzer channel with zero count");

endmodule

// ===== src/dual_channel_event_pwm.sv =====
// ---------------------------------------------------------------------------
// dual_channel_event_pwm
// Two-channel (motor, buzzer) PWM scheduler sharing one interval timer.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per
//   transaction: timer expiry, set motor speed (0.01 % units), buzzer on/off
//   or set buzzer volume. Every command returns exactly one transaction on
//   the output channel (out_valid_o / out_stall_i) with both pin levels,
//   timer run flag, ticks to the next edge and the up-counter reload value.
//   Periods are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle;
//   index 0 is the motor period, index 1 the buzzer period (below 2 acts as 2).
// Timing:
//   The accepting edge loads the period*duty product stage, then the
//   reciprocal multiply for the /10000 or /100 fills the quotient stage,
//   followed by a queue write and the sequencer's registered result.
//   Throughput is one transaction per cycle while out_stall_i is low; the
//   sequencer's registered state update is the loop that sets it.
// Reset:
//   Both channels off, timer flagged running with delta 1, volume 10 %,
//   periods 400 and 1000 ticks. No clearing pass.
// Backpressure:
//   A stalled result holds in the output register; the sequencer stops, the
//   queue fills, and the front end then raises in_stall_o.
// ---------------------------------------------------------------------------
module dual_channel_event_pwm #(
  parameter int unsigned TimerBits  = dcep_pkg::TIMER_BITS_DEF,
  parameter int unsigned QueueDepth = dcep_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [dcep_pkg::TICK_W-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   command_i,
  input  logic [dcep_pkg::SPEED_W-1:0] speed_hundredths_i,
  input  logic                         buzzer_on_i,
  input  logic [dcep_pkg::VOL_W-1:0]   volume_percent_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         motor_level_o,
  output logic                         buzzer_level_o,
  output logic                         timer_running_o,
  output logic [dcep_pkg::TICK_W-1:0]  tick_delta_o,
  output logic [dcep_pkg::TICK_W-1:0]  timer_reload_o
);

  // front end -> queue
  logic                push;
  dcep_pkg::back_cmd_t push_data;
  logic                q_full;
  // queue -> sequencer
  logic                pop;
  dcep_pkg::back_cmd_t pop_data;
  logic                q_empty;

  // classify and compute high/low times
  dcep_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .speed_hundredths_i (speed_hundredths_i),
    .buzzer_on_i        (buzzer_on_i),
    .volume_percent_i   (volume_percent_i),
    .push_o             (push),
    .push_data_o        (push_data),
    .full_i             (q_full)
  );

  // decouples front end and sequencer stalls
  dcep_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty)
  );

  // channel state, timer scheduling, output register
  dcep_back #(
    .TimerBits (TimerBits)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (pop_data),
    .empty_i         (q_empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .motor_level_o   (motor_level_o),
    .buzzer_level_o  (buzzer_level_o),
    .timer_running_o (timer_running_o),
    .tick_delta_o    (tick_delta_o),
    .timer_reload_o  (timer_reload_o)
  );

endmodule
